// ===== src/btd_pkg.sv =====
`timescale 1ns / 1ps
package btd_pkg;

	typedef struct packed {
		logic [7:0] code_byte;
		logic       line_first;
		logic       line_last;
	} tok_item_t;

	typedef struct packed {
		logic [7:0] text_char;
		logic       char_valid;
		logic       item_done;
		logic       line_done;
		logic [1:0] line_status;
	} txt_item_t;

	// parse modes
	localparam logic [2:0] M_NORMAL = 3'd0;
	localparam logic [2:0] M_TEXT   = 3'd1;
	localparam logic [2:0] M_QLEN   = 3'd2;
	localparam logic [2:0] M_QBODY  = 3'd3;
	localparam logic [2:0] M_SLEN   = 3'd4;
	localparam logic [2:0] M_SBODY  = 3'd5;
	localparam logic [2:0] M_NUMHI  = 3'd6;
	localparam logic [2:0] M_NUMLO  = 3'd7;

	// line status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD_TOK = 2'd1;
	localparam logic [1:0] ST_NO_DATA = 2'd2;
	localparam logic [1:0] ST_BAD_END = 2'd3;

	localparam logic [7:0] TOK_SEP_LO = 8'hB3;
	localparam logic [7:0] TOK_QSTR   = 8'hC7;
	localparam logic [7:0] TOK_PSTR   = 8'hC8;
	localparam logic [7:0] TOK_NUM    = 8'hC9;
	localparam logic [7:0] TOK_COLON  = 8'hB5;
	localparam logic [7:0] TOK_ELSE   = 8'h82;
	localparam logic [7:0] TOK_NOSEP  = 8'hFD;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	localparam int NUM_PLACES = 5;

	// One expansion command handed from the front to the back.
	typedef struct packed {
		logic [1:0]  nsp;     // leading spaces
		logic [1:0]  nch;     // literal chars: ch0, then quotes
		logic [7:0]  ch0;
		logic        kw_en;
		logic [6:0]  kw_idx;
		logic        num_en;
		logic [15:0] num;
		logic        st_en;
		logic [1:0]  st;
	} cmd_t;

	typedef struct packed {
		logic [3:0]  len;
		logic [79:0] text;   // right aligned, last char in [7:0]
	} kw_t;

	function automatic kw_t kw_lookup(input logic [6:0] idx);
		kw_t k;
		k = '{len: 4'd0, text: 80'd0};
		case (idx)
			7'h01: k = '{4'd4, 80'("ELSE")};
			7'h02: k = '{4'd2, 80'("::")};
			7'h03: k = '{4'd1, 80'("!")};
			7'h04: k = '{4'd2, 80'("IF")};
			7'h05: k = '{4'd2, 80'("GO")};
			7'h06: k = '{4'd4, 80'("GOTO")};
			7'h07: k = '{4'd5, 80'("GOSUB")};
			7'h08: k = '{4'd6, 80'("RETURN")};
			7'h09: k = '{4'd3, 80'("DEF")};
			7'h0A: k = '{4'd3, 80'("DIM")};
			7'h0B: k = '{4'd3, 80'("END")};
			7'h0C: k = '{4'd3, 80'("FOR")};
			7'h0D: k = '{4'd3, 80'("LET")};
			7'h0E: k = '{4'd5, 80'("BREAK")};
			7'h0F: k = '{4'd7, 80'("UNBREAK")};
			7'h10: k = '{4'd5, 80'("TRACE")};
			7'h11: k = '{4'd7, 80'("UNTRACE")};
			7'h12: k = '{4'd5, 80'("INPUT")};
			7'h13: k = '{4'd4, 80'("DATA")};
			7'h14: k = '{4'd7, 80'("RESTORE")};
			7'h15: k = '{4'd9, 80'("RANDOMIZE")};
			7'h16: k = '{4'd4, 80'("NEXT")};
			7'h17: k = '{4'd4, 80'("READ")};
			7'h18: k = '{4'd4, 80'("STOP")};
			7'h19: k = '{4'd6, 80'("DELETE")};
			7'h1A: k = '{4'd3, 80'("REM")};
			7'h1B: k = '{4'd2, 80'("ON")};
			7'h1C: k = '{4'd5, 80'("PRINT")};
			7'h1D: k = '{4'd4, 80'("CALL")};
			7'h1E: k = '{4'd6, 80'("OPTION")};
			7'h1F: k = '{4'd4, 80'("OPEN")};
			7'h20: k = '{4'd5, 80'("CLOSE")};
			7'h21: k = '{4'd3, 80'("SUB")};
			7'h22: k = '{4'd7, 80'("DISPLAY")};
			7'h23: k = '{4'd5, 80'("IMAGE")};
			7'h24: k = '{4'd6, 80'("ACCEPT")};
			7'h25: k = '{4'd5, 80'("ERROR")};
			7'h26: k = '{4'd7, 80'("WARNING")};
			7'h27: k = '{4'd7, 80'("SUBEXIT")};
			7'h28: k = '{4'd6, 80'("SUBEND")};
			7'h29: k = '{4'd3, 80'("RUN")};
			7'h2A: k = '{4'd6, 80'("LINPUT")};
			7'h30: k = '{4'd4, 80'("THEN")};
			7'h31: k = '{4'd2, 80'("TO")};
			7'h32: k = '{4'd4, 80'("STEP")};
			7'h33: k = '{4'd1, 80'(",")};
			7'h34: k = '{4'd1, 80'(";")};
			7'h35: k = '{4'd1, 80'(":")};
			7'h36: k = '{4'd1, 80'(")")};
			7'h37: k = '{4'd1, 80'("(")};
			7'h38: k = '{4'd1, 80'("&")};
			7'h3A: k = '{4'd4, 80'(" OR ")};
			7'h3B: k = '{4'd5, 80'(" AND ")};
			7'h3C: k = '{4'd5, 80'(" XOR ")};
			7'h3D: k = '{4'd5, 80'(" NOT ")};
			7'h3E: k = '{4'd1, 80'("=")};
			7'h3F: k = '{4'd1, 80'("<")};
			7'h40: k = '{4'd1, 80'(">")};
			7'h41: k = '{4'd1, 80'("+")};
			7'h42: k = '{4'd1, 80'("-")};
			7'h43: k = '{4'd1, 80'("*")};
			7'h44: k = '{4'd1, 80'("/")};
			7'h45: k = '{4'd1, 80'("^")};
			7'h4A: k = '{4'd3, 80'("EOF")};
			7'h4B: k = '{4'd3, 80'("ABS")};
			7'h4C: k = '{4'd3, 80'("ATN")};
			7'h4D: k = '{4'd3, 80'("COS")};
			7'h4E: k = '{4'd3, 80'("EXP")};
			7'h4F: k = '{4'd3, 80'("INT")};
			7'h50: k = '{4'd3, 80'("LOG")};
			7'h51: k = '{4'd3, 80'("SGN")};
			7'h52: k = '{4'd3, 80'("SIN")};
			7'h53: k = '{4'd3, 80'("SQR")};
			7'h54: k = '{4'd3, 80'("TAN")};
			7'h55: k = '{4'd3, 80'("LEN")};
			7'h56: k = '{4'd4, 80'("CHR$")};
			7'h57: k = '{4'd3, 80'("RND")};
			7'h58: k = '{4'd4, 80'("SEG$")};
			7'h59: k = '{4'd3, 80'("POS")};
			7'h5A: k = '{4'd3, 80'("VAL")};
			7'h5B: k = '{4'd4, 80'("STR$")};
			7'h5C: k = '{4'd3, 80'("ASC")};
			7'h5D: k = '{4'd2, 80'("PI")};
			7'h5E: k = '{4'd3, 80'("REC")};
			7'h5F: k = '{4'd3, 80'("MAX")};
			7'h60: k = '{4'd3, 80'("MIN")};
			7'h61: k = '{4'd4, 80'("RPT$")};
			7'h68: k = '{4'd7, 80'("NUMERIC")};
			7'h69: k = '{4'd5, 80'("DIGIT")};
			7'h6A: k = '{4'd6, 80'("UALPHA")};
			7'h6B: k = '{4'd4, 80'("SIZE")};
			7'h6C: k = '{4'd3, 80'("ALL")};
			7'h6D: k = '{4'd5, 80'("USING")};
			7'h6E: k = '{4'd4, 80'("BEEP")};
			7'h6F: k = '{4'd5, 80'("ERASE")};
			7'h70: k = '{4'd2, 80'("AT")};
			7'h71: k = '{4'd4, 80'("BASE")};
			7'h73: k = '{4'd8, 80'("VARIABLE")};
			7'h74: k = '{4'd8, 80'("RELATIVE")};
			7'h75: k = '{4'd8, 80'("INTERNAL")};
			7'h76: k = '{4'd10, 80'("SEQUENTIAL")};
			7'h77: k = '{4'd6, 80'("OUTPUT")};
			7'h78: k = '{4'd6, 80'("UPDATE")};
			7'h79: k = '{4'd6, 80'("APPEND")};
			7'h7A: k = '{4'd5, 80'("FIXED")};
			7'h7B: k = '{4'd9, 80'("PERMANENT")};
			7'h7C: k = '{4'd3, 80'("TAB")};
			7'h7D: k = '{4'd1, 80'("#")};
			7'h7E: k = '{4'd8, 80'("VALIDATE")};
			default: k = '{len: 4'd0, text: 80'd0};
		endcase
		return k;
	endfunction

endpackage

// ===== src/btd_front.sv =====
`timescale 1ns / 1ps
module btd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  btd_pkg::tok_item_t item,
	output logic              push,
	output btd_pkg::cmd_t     cmd
);
	import btd_pkg::*;

	logic       ps_q, hs_q, lsp_q, lco_q, ne_q, fl_q;
	logic [2:0] mode_q;
	logic [7:0] rem_q, nhi_q;

	logic       ps, hs, lsp, lco, ne, fl, tok_go, top;
	logic [2:0] mode;
	logic [7:0] rem, nhi, b;
	kw_t        kw;

	assign b  = item.code_byte;
	assign kw = kw_lookup(b[6:0]);

	always_comb begin
		cmd = '0;
		ps = ps_q; hs = hs_q; lsp = lsp_q; lco = lco_q; ne = ne_q; fl = fl_q;
		mode = mode_q; rem = rem_q; nhi = nhi_q;
		tok_go = 1'b0;
		if (item.line_first) begin
			ps = 1'b0; hs = 1'b0; lsp = 1'b0; lco = 1'b0; ne = 1'b0; fl = 1'b0;
			mode = M_NORMAL; rem = 8'd0; nhi = 8'd0;
		end
		top = (mode == M_NORMAL);
		if (!fl) begin
			if (item.line_last && b != 8'd0) begin
				cmd.st_en = 1'b1; cmd.st = ST_BAD_END; fl = 1'b1; mode = M_NORMAL;
			end else begin
				unique case (mode)
					M_NORMAL: tok_go = 1'b1;
					M_TEXT: begin
						if (!b[7]) begin
							if (b == 8'd0 && item.line_last) begin
								cmd.st_en = 1'b1; cmd.st = ST_OK; fl = 1'b1; mode = M_NORMAL;
							end else begin
								cmd.nch = 2'd1; cmd.ch0 = b;
								ne = 1'b1; lsp = (b == CH_SPACE); lco = (b == CH_COLON);
							end
						end else begin
							mode = M_NORMAL;
							tok_go = 1'b1;
						end
					end
					M_QLEN: begin
						if (b == 8'd0) begin
							cmd.nch = 2'd1; cmd.ch0 = CH_QUOTE;
							ne = 1'b1; lsp = 1'b0; lco = 1'b0; mode = M_NORMAL;
						end else begin
							rem = b; mode = M_QBODY;
						end
					end
					M_QBODY: begin
						cmd.ch0 = b;
						cmd.nch = 2'd1 + {1'b0, b == CH_QUOTE} + {1'b0, rem <= 8'd1};
						ne = 1'b1;
						if (b == CH_QUOTE || rem <= 8'd1) begin
							lsp = 1'b0; lco = 1'b0;
						end else begin
							lsp = (b == CH_SPACE); lco = (b == CH_COLON);
						end
						if (rem <= 8'd1) begin
							rem = 8'd0; mode = M_NORMAL;
						end else begin
							rem = rem - 8'd1;
						end
					end
					M_SLEN: begin
						if (b == 8'd0) mode = M_NORMAL;
						else begin
							rem = b; mode = M_SBODY;
						end
					end
					M_SBODY: begin
						cmd.nch = 2'd1; cmd.ch0 = b;
						ne = 1'b1; lsp = (b == CH_SPACE); lco = (b == CH_COLON);
						if (rem <= 8'd1) begin
							rem = 8'd0; mode = M_NORMAL;
						end else begin
							rem = rem - 8'd1;
						end
					end
					M_NUMHI: begin
						nhi = b; mode = M_NUMLO;
					end
					M_NUMLO: begin
						cmd.num_en = 1'b1; cmd.num = {nhi, b};
						ne = 1'b1; lsp = 1'b0; lco = 1'b0; mode = M_NORMAL;
					end
					default: mode = M_NORMAL;
				endcase

				if (tok_go) begin
					if (top && hs) begin
						cmd.nsp = cmd.nsp + 2'd1; ne = 1'b1; lsp = 1'b1; lco = 1'b0;
						hs = 1'b0;
					end
					if (b < TOK_SEP_LO || b >= TOK_PSTR) begin
						hs = 1'b1;
						if (ps && ne && !lsp) begin
							ps = (b != 8'd0);
							cmd.nsp = cmd.nsp + 2'd1; ne = 1'b1; lsp = 1'b1; lco = 1'b0;
						end
					end
					if ((b == TOK_COLON || b == TOK_ELSE) && ne && !lco) begin
						cmd.nsp = cmd.nsp + 2'd1; ne = 1'b1; lsp = 1'b1; lco = 1'b0;
					end
					{ps, hs} = {hs, ps};
					if (!b[7]) begin
						if (b == 8'd0 && item.line_last) begin
							cmd.st_en = 1'b1; cmd.st = ST_OK; fl = 1'b1; mode = M_NORMAL;
						end else begin
							cmd.nch = 2'd1; cmd.ch0 = b;
							ne = 1'b1; lsp = (b == CH_SPACE); lco = (b == CH_COLON);
							mode = M_TEXT;
						end
					end else if (b == TOK_QSTR) begin
						cmd.nch = 2'd1; cmd.ch0 = CH_QUOTE;
						ne = 1'b1; lsp = 1'b0; lco = 1'b0;
						ps = 1'b1; hs = 1'b0; mode = M_QLEN;
					end else if (b == TOK_PSTR || b == TOK_NUM) begin
						hs = 1'b0;
						mode = (b == TOK_PSTR) ? M_SLEN : M_NUMHI;
					end else if (kw.len == 4'd0) begin
						cmd.st_en = 1'b1; cmd.st = ST_BAD_TOK; fl = 1'b1; mode = M_NORMAL;
					end else begin
						cmd.kw_en = 1'b1; cmd.kw_idx = b[6:0];
						ne = 1'b1; lsp = (kw.text[7:0] == CH_SPACE);
						lco = (kw.text[7:0] == CH_COLON);
						mode = M_NORMAL;
						if (b < TOK_SEP_LO) begin
							ps = 1'b0; hs = 1'b1;
						end else begin
							if (b == TOK_NOSEP) ps = 1'b0;
							hs = 1'b0;
						end
					end
				end

				// close the line on its last byte
				if (item.line_last && !fl) begin
					cmd.st_en = 1'b1;
					cmd.st = (mode == M_NORMAL || mode == M_TEXT) ? ST_OK : ST_NO_DATA;
					fl = 1'b1; mode = M_NORMAL;
				end
			end
		end
	end

	assign push = accept && (cmd.nsp != 2'd0 || cmd.nch != 2'd0 || cmd.kw_en ||
		cmd.num_en || cmd.st_en);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ps_q <= 1'b0; hs_q <= 1'b0; lsp_q <= 1'b0; lco_q <= 1'b0;
			ne_q <= 1'b0; fl_q <= 1'b0; mode_q <= M_NORMAL;
			rem_q <= 8'd0; nhi_q <= 8'd0;
		end else if (accept) begin
			ps_q <= ps; hs_q <= hs; lsp_q <= lsp; lco_q <= lco;
			ne_q <= ne; fl_q <= fl; mode_q <= mode;
			rem_q <= rem; nhi_q <= nhi;
		end
	end

endmodule

// ===== src/btd_fifo.sv =====
`timescale 1ns / 1ps
module btd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			if (pop)  rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			if (push && !pop) cnt_q <= cnt_q + CW'(1);
			else if (pop && !push) cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule

// ===== src/btd_back.sv =====
`timescale 1ns / 1ps
module btd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  btd_pkg::cmd_t      q_cmd,
	output logic               pop,
	output logic               txt_valid,
	input  logic               txt_stall,
	output btd_pkg::txt_item_t txt_item
);
	import btd_pkg::*;

	logic          busy_q, started_q, out_valid_q;
	cmd_t          cur_q, nxt;
	logic [3:0]    kwpos_q, kwpos_n;
	logic [2:0]    place_q, place_n;
	logic          started_n;
	txt_item_t     out_q, res;
	logic          produce, done_after, step;
	kw_t           kw;
	logic [6:0]    shamt;
	logic [16:0]   pow, sub, val;
	logic [3:0]    dig;
	logic          emit_dig;

	assign kw    = kw_lookup(cur_q.kw_idx);
	assign shamt = {kw.len - 4'd1 - kwpos_q, 3'b000};
	assign val   = {1'b0, cur_q.num};

	always_comb begin
		unique case (place_q)
			3'd0: pow = 17'd10000;
			3'd1: pow = 17'd1000;
			3'd2: pow = 17'd100;
			3'd3: pow = 17'd10;
			default: pow = 17'd1;
		endcase
	end

	// pick the digit of this place by comparing against its multiples
	always_comb begin
		dig = 4'd0;
		sub = 17'd0;
		for (int k = 1; k < 10; k++) begin
			if (val >= 17'(k) * pow) begin
				dig = 4'(k);
				sub = 17'(k) * pow;
			end
		end
	end

	assign emit_dig = (dig != 4'd0) || started_q || (place_q == 3'(NUM_PLACES - 1));

	always_comb begin
		nxt = cur_q;
		kwpos_n = kwpos_q;
		place_n = place_q;
		started_n = started_q;
		res = '0;
		produce = 1'b1;
		if (cur_q.nsp != 2'd0) begin
			res.text_char = CH_SPACE; res.char_valid = 1'b1;
			nxt.nsp = cur_q.nsp - 2'd1;
		end else if (cur_q.nch != 2'd0) begin
			res.text_char = cur_q.ch0; res.char_valid = 1'b1;
			nxt.nch = cur_q.nch - 2'd1;
			nxt.ch0 = CH_QUOTE;
		end else if (cur_q.kw_en) begin
			res.text_char = 8'(kw.text >> shamt); res.char_valid = 1'b1;
			if (kwpos_q == kw.len - 4'd1) nxt.kw_en = 1'b0;
			else kwpos_n = kwpos_q + 4'd1;
		end else if (cur_q.num_en) begin
			produce = emit_dig;
			res.text_char = CH_ZERO + {4'd0, dig}; res.char_valid = 1'b1;
			nxt.num = 16'(val - sub);
			started_n = started_q | emit_dig;
			if (place_q == 3'(NUM_PLACES - 1)) nxt.num_en = 1'b0;
			else place_n = place_q + 3'd1;
		end else begin
			res.line_done = 1'b1; res.line_status = cur_q.st;
			nxt.st_en = 1'b0;
		end
		done_after = (nxt.nsp == 2'd0) && (nxt.nch == 2'd0) && !nxt.kw_en &&
			!nxt.num_en && !nxt.st_en;
		res.item_done = done_after;
	end

	assign step = busy_q && (!out_valid_q || !txt_stall);
	assign pop  = !q_empty && (!busy_q || (step && done_after));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0; out_valid_q <= 1'b0; started_q <= 1'b0;
			kwpos_q <= 4'd0; place_q <= 3'd0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1; kwpos_q <= 4'd0; place_q <= 3'd0; started_q <= 1'b0;
			end else if (step) begin
				busy_q <= !done_after;
				kwpos_q <= kwpos_n; place_q <= place_n; started_q <= started_n;
			end
			if (!out_valid_q || !txt_stall) out_valid_q <= step && produce;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cur_q <= q_cmd;
		else if (step) cur_q <= nxt;
		if (step && produce) out_q <= res;
	end

	assign txt_valid = out_valid_q;
	assign txt_item  = out_q;

endmodule

// ===== src/basic_token_line_detokenizer.sv =====
`timescale 1ns / 1ps
// Turns a tokenized program line, one byte per transaction, into listing
// characters, one per transaction, and closes each line with a status
// transaction. The front classifies a byte and updates the parse state in
// the cycle it is taken, so bytes enter one per cycle while the command
// queue has room. The back expands each command one character or status
// per cycle while the output is not stalled, but a statement number is
// stepped through all five decimal places with leading zeros suppressed.
// Bytes that yield nothing push no command into the queue.
// QUEUE_DEPTH sets how many expanded commands may wait.
module basic_token_line_detokenizer #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               tok_valid,
	output logic               tok_stall,
	input  btd_pkg::tok_item_t tok_item,
	output logic               txt_valid,
	input  logic               txt_stall,
	output btd_pkg::txt_item_t txt_item
);
	import btd_pkg::*;

	logic accept, push, pop, q_full, q_empty;
	cmd_t f_cmd, q_cmd;

	// take a transaction whenever the queue can hold its command
	assign tok_stall = q_full;
	assign accept    = tok_valid && !q_full;

	// front: parse state and spacing decisions
	btd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (tok_item),
		.push   (push),
		.cmd    (f_cmd)
	);

	// queue: decouple parsing from expansion
	btd_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (f_cmd),
		.pop     (pop),
		.rd_data (q_cmd),
		.full    (q_full),
		.empty   (q_empty)
	);

	// back: expand spaces, literals, keywords, numbers and status
	btd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_cmd     (q_cmd),
		.pop       (pop),
		.txt_valid (txt_valid),
		.txt_stall (txt_stall),
		.txt_item  (txt_item)
	);

endmodule
